### rtl/lfu_pkg.sv
// ---------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU key-value store and its cell row.
// ---------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  // Payload widths fixed by the interface
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CFG_ADDR_W = 3;

  // Register map (word index = paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Update command broadcast to every cell
  typedef struct packed {
    logic ins_en;  // insert the new entry, shifting the row around it
    logic rm_en;   // one entry (at rm_idx) leaves the row
    logic val_wr;  // overwrite the value of the entry at rm_idx in place
  } ctl_t;

endpackage

`default_nettype wire

### rtl/lfu_cell.sv
// ---------------------------------------------------------------------------
// lfu_cell
// One slot of the sorted entry row. The row is kept ascending by use count,
// and among equal counts by the time the count was reached, so slot 0 always
// holds the victim. On an update a cell holds, takes its upper neighbor
// (close the gap), its lower neighbor (open a gap) or the new entry, or rewrites its value in place.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_cell #(
  parameter int COUNT_BITS = 16,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // broadcast command
  input  lfu_pkg::ctl_t              ctl,
  input  wire [IDX_W-1:0]            rm_idx,
  input  wire [COUNT_BITS-1:0]       ins_cnt,
  input  wire [lfu_pkg::DATA_W-1:0]  ins_key,
  input  wire [lfu_pkg::DATA_W-1:0]  ins_val,
  input  wire [lfu_pkg::DATA_W-1:0]  look_key,
  // lower neighbor (toward slot 0)
  input  wire                        prv_vld,
  input  wire [lfu_pkg::DATA_W-1:0]  prv_key,
  input  wire [lfu_pkg::DATA_W-1:0]  prv_val,
  input  wire [COUNT_BITS-1:0]       prv_cnt,
  input  wire                        prv_le,
  // upper neighbor
  input  wire                        nxt_vld,
  input  wire [lfu_pkg::DATA_W-1:0]  nxt_key,
  input  wire [lfu_pkg::DATA_W-1:0]  nxt_val,
  input  wire [COUNT_BITS-1:0]       nxt_cnt,
  input  wire                        nxt_le,
  // own contents
  output logic                       vld,
  output logic [lfu_pkg::DATA_W-1:0] key,
  output logic [lfu_pkg::DATA_W-1:0] val,
  output logic [COUNT_BITS-1:0]      cnt,
  output logic                       le,
  output logic                       match
);
  import lfu_pkg::*;

  logic                  vld_r;
  logic [DATA_W-1:0]     key_r;
  logic [DATA_W-1:0]     val_r;
  logic [COUNT_BITS-1:0] cnt_r;

  logic at_or_after_rm;
  logic at_or_before_rm;
  logic take_nxt;
  logic take_new;
  logic take_prv;
  logic here;

  assign vld   = vld_r;
  assign key   = key_r;
  assign val   = val_r;
  assign cnt   = cnt_r;
  assign match = vld_r && (key_r == look_key);

  // belongs before the new entry in the sorted row
  assign le = vld_r && (cnt_r <= ins_cnt);

  assign here            = (IDX_W'(IDX) == rm_idx);
  assign at_or_after_rm  = ctl.rm_en && (IDX_W'(IDX) >= rm_idx);
  assign at_or_before_rm = !ctl.rm_en || (IDX_W'(IDX) <= rm_idx);

  // move selection; cell 0 sees prv_le tied high, the last cell nxt_le low
  assign take_nxt = at_or_after_rm && nxt_le;
  assign take_new = (at_or_after_rm && le && !nxt_le) ||
                    (at_or_before_rm && !le && prv_le);
  assign take_prv = at_or_before_rm && !le && !prv_le;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.ins_en) begin
      if (take_new) begin
        vld_r <= 1'b1;
      end else if (take_nxt) begin
        vld_r <= nxt_vld;
      end else if (take_prv) begin
        vld_r <= prv_vld;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (take_new) begin
        key_r <= ins_key;
        val_r <= ins_val;
        cnt_r <= ins_cnt;
      end else if (take_nxt) begin
        key_r <= nxt_key;
        val_r <= nxt_val;
        cnt_r <= nxt_cnt;
      end else if (take_prv) begin
        key_r <= prv_key;
        val_r <= prv_val;
        cnt_r <= prv_cnt;
      end
    end else if (ctl.val_wr && here) begin
      val_r <= ins_val;
    end
  end

endmodule

`default_nettype wire

### rtl/lfu_replacement_cache_core.sv
// ---------------------------------------------------------------------------
// lfu_replacement_cache_core
// Fully associative key-value store with least-frequently-used replacement
// and oldest-first tie break, built as a sorted row of entry cells.
//
//   channel  dir  beat accepted when        payload
//   in_      in   in_valid  && !in_stall    op, key, value
//   out_     out  out_valid && !out_stall   hit, read_value, evicted,
//                                           evicted_key
//   cfg      in   psel && penable && pwrite capacity at address 0
//
// Each request passes through a lookup cycle (key match across all cells,
// hit value and count captured) and an update cycle in which the cell row
// shifts by at most one place. A new request can be taken in the update
// cycle or while idle. Results sit in an output register; while it is
// stalled and full the update cycle holds. Reset clears all valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_replacement_cache_core #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // request channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_op,
  input  wire signed [lfu_pkg::DATA_W-1:0] in_key,
  input  wire signed [lfu_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_hit,
  output logic signed [lfu_pkg::DATA_W-1:0] out_read_value,
  output logic                             out_evicted,
  output logic signed [lfu_pkg::DATA_W-1:0] out_evicted_key,
  // configuration
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [lfu_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire [lfu_pkg::DATA_W-1:0]        pwdata,
  output logic [lfu_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import lfu_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;

  // request latch
  logic                  op_r;
  logic [DATA_W-1:0]     key_r;
  logic [DATA_W-1:0]     val_in_r;
  // lookup results
  logic                  hit_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [DATA_W-1:0]     hit_val_r;
  logic [COUNT_BITS-1:0] bump_cnt_r;
  logic                  sat_r;
  // store state
  logic [CAP_W-1:0]      capacity_r;
  logic [FILL_W-1:0]     fill_r;
  // result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [DATA_W-1:0]     out_rd_r;
  logic                  out_ev_r;
  logic [DATA_W-1:0]     out_evk_r;

  logic accept;
  logic upd_go;
  logic cfg_wr;

  // cell row signals
  logic [ENTRIES-1:0]    vld_a;
  logic [ENTRIES-1:0]    le_a;
  logic [ENTRIES-1:0]    match_a;
  logic [DATA_W-1:0]     key_a [ENTRIES];
  logic [DATA_W-1:0]     val_a [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_a [ENTRIES];

  // lookup combinational
  logic                  look_hit;
  logic [IDX_W-1:0]      look_idx;
  logic [DATA_W-1:0]     look_val;
  logic [COUNT_BITS-1:0] look_cnt;

  // update decisions
  ctl_t                  ctl_raw;
  ctl_t                  ctl;
  logic [IDX_W-1:0]      rm_idx;
  logic [COUNT_BITS-1:0] ins_cnt;
  logic [DATA_W-1:0]     ins_val;
  logic                  fill_inc;
  logic                  ev;
  logic [DATA_W-1:0]     evk;
  logic [DATA_W-1:0]     rd;
  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic [CMP_W-1:0]      fill_ext;

  // handshakes
  assign upd_go   = (state_r == S_UPD) && (!out_valid_r || !out_stall);
  assign in_stall = !((state_r == S_IDLE) || upd_go);
  assign accept   = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1] == REG_CAPACITY);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_CAPACITY) ?
                  {{(DATA_W-CAP_W){1'b0}}, capacity_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // cell row
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                  p_vld, n_vld, p_le, n_le;
    logic [DATA_W-1:0]     p_key, n_key, p_val, n_val;
    logic [COUNT_BITS-1:0] p_cnt, n_cnt;

    if (i == 0) begin : g_lo
      assign p_vld = 1'b0;
      assign p_key = '0;
      assign p_val = '0;
      assign p_cnt = '0;
      assign p_le  = 1'b1;
    end else begin : g_lo
      assign p_vld = vld_a[i-1];
      assign p_key = key_a[i-1];
      assign p_val = val_a[i-1];
      assign p_cnt = cnt_a[i-1];
      assign p_le  = le_a[i-1];
    end

    if (i == ENTRIES - 1) begin : g_hi
      assign n_vld = 1'b0;
      assign n_key = '0;
      assign n_val = '0;
      assign n_cnt = '0;
      assign n_le  = 1'b0;
    end else begin : g_hi
      assign n_vld = vld_a[i+1];
      assign n_key = key_a[i+1];
      assign n_val = val_a[i+1];
      assign n_cnt = cnt_a[i+1];
      assign n_le  = le_a[i+1];
    end

    lfu_cell #(
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .rm_idx   (rm_idx),
      .ins_cnt  (ins_cnt),
      .ins_key  (key_r),
      .ins_val  (ins_val),
      .look_key (key_r),
      .prv_vld  (p_vld),
      .prv_key  (p_key),
      .prv_val  (p_val),
      .prv_cnt  (p_cnt),
      .prv_le   (p_le),
      .nxt_vld  (n_vld),
      .nxt_key  (n_key),
      .nxt_val  (n_val),
      .nxt_cnt  (n_cnt),
      .nxt_le   (n_le),
      .vld      (vld_a[i]),
      .key      (key_a[i]),
      .val      (val_a[i]),
      .cnt      (cnt_a[i]),
      .le       (le_a[i]),
      .match    (match_a[i])
    );
  end

  // lookup: keys are unique, so at most one match; OR the selections
  always_comb begin
    look_hit = |match_a;
    look_idx = '0;
    look_val = '0;
    look_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_a[i]) begin
        look_idx = look_idx | IDX_W'(i);
        look_val = look_val | val_a[i];
        look_cnt = look_cnt | cnt_a[i];
      end
    end
  end

  // update decisions
  assign cap_ext  = CMP_W'(capacity_r);
  assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign fill_ext = CMP_W'(fill_r);

  always_comb begin
    ctl_raw  = '0;
    rm_idx   = hit_idx_r;
    ins_cnt  = bump_cnt_r;
    ins_val  = hit_val_r;
    fill_inc = 1'b0;
    ev       = 1'b0;
    evk      = '0;
    if (op_r == OP_GET) begin
      // bump on hit: entry moves behind all entries of its new count
      if (hit_r && !sat_r) begin
        ctl_raw.rm_en  = 1'b1;
        ctl_raw.ins_en = 1'b1;
      end
    end else if (cap_eff != '0) begin
      ins_val = val_in_r;
      if (hit_r) begin
        if (sat_r) begin
          ctl_raw.val_wr = 1'b1;
        end else begin
          ctl_raw.rm_en  = 1'b1;
          ctl_raw.ins_en = 1'b1;
        end
      end else begin
        ctl_raw.ins_en = 1'b1;
        ins_cnt        = COUNT_BITS'(1);
        if (fill_ext >= cap_eff) begin
          // full: slot 0 is the victim
          ctl_raw.rm_en = 1'b1;
          rm_idx        = '0;
          ev            = 1'b1;
          evk           = key_a[0];
        end else begin
          fill_inc = 1'b1;
        end
      end
    end
  end

  assign ctl = upd_go ? ctl_raw : '0;
  assign rd  = ((op_r == OP_GET) && hit_r) ? hit_val_r : '0;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_LOOK : S_IDLE;
      S_LOOK:  state_nxt = S_UPD;
      S_UPD: begin
        if (upd_go) begin
          state_nxt = accept ? S_LOOK : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, fill level and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go && fill_inc) begin
        fill_r <= fill_r + FILL_W'(1);
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
        out_hit_r   <= hit_r;
        out_rd_r    <= rd;
        out_ev_r    <= ev;
        out_evk_r   <= evk;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request latch and lookup capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      key_r    <= in_key;
      val_in_r <= in_value;
    end
    if (state_r == S_LOOK) begin
      hit_r      <= look_hit;
      hit_idx_r  <= look_idx;
      hit_val_r  <= look_val;
      bump_cnt_r <= look_cnt + COUNT_BITS'(1);
      sat_r      <= &look_cnt;
    end
  end

`ifndef SYNTHESIS
  // valid entries always fill the low slots, one per counted entry
  a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_a) == 32'(fill_r))
    else $error("fill level disagrees with valid cells");

  // a blocked result register holds the update stage
  a_upd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) && out_valid_r && out_stall |=> (state_r == S_UPD))
    else $error("update left while result register blocked");

  // every accepted request goes to lookup next
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOOK))
    else $error("accepted request did not enter lookup");

  // a completed update always presents a result
  a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_valid_r)
    else $error("update completed without result");
`endif

endmodule

`default_nettype wire

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LFU key-value store. A behavioral copy of the
// store (use counts, rank by time of last count change, capacity register)
// predicts the reply to each request beat, and replies are checked in order
// as they leave the block. Directed tests cover the equal-count tie break,
// extreme keys, eviction order, capacity zero and out-of-range capacity,
// followed by random traffic over several capacity settings with bursty
// requests and a stalling receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import lfu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 16;
  localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int LIMIT      = 2_000_000;
  localparam int POOL_SZ    = 32;

  localparam logic [CFG_ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } reply_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // DUT inputs, known from time zero
  logic              in_valid  = 1'b0;
  logic              in_op     = OP_GET;
  logic [DATA_W-1:0] in_key    = '0;
  logic [DATA_W-1:0] in_value  = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata    = '0;

  // DUT outputs
  logic              in_stall;
  logic              out_valid;
  logic              out_hit;
  logic [DATA_W-1:0] out_read_value;
  logic              out_evicted;
  logic [DATA_W-1:0] out_evicted_key;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lfu_replacement_cache_core #(
    .ENTRIES   (SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ---------------------------------------------------------------------
  // Store image used for prediction
  // ---------------------------------------------------------------------
  logic              slot_used [SLOTS];
  logic [DATA_W-1:0] slot_key  [SLOTS];
  logic [DATA_W-1:0] slot_val  [SLOTS];
  int unsigned       slot_cnt  [SLOTS];
  int unsigned       slot_rank [SLOTS];
  int unsigned       n_used = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;

  // expected replies in request order, a ring far deeper than the few in flight
  reply_t     due_q [64];
  logic [5:0] due_wr = '0;
  logic [5:0] due_rd = '0;

  int     error_count = 0;
  int     cycle_count = 0;
  logic   stalls_on   = 1'b1;

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
  end

  function automatic void due_put(reply_t r);
    due_q[due_wr] = r;
    due_wr = due_wr + 6'd1;
  endfunction

  function automatic reply_t due_take();
    reply_t r;
    r = due_q[due_rd];
    due_rd = due_rd + 6'd1;
    return r;
  endfunction

  // drop rank r: later ranks move one step earlier
  function automatic void retire_rank(int unsigned r);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
  endfunction

  // count bump; a saturated entry keeps both count and rank
  function automatic void bump_use(int s);
    if (slot_cnt[s] >= COUNT_MAX) return;
    slot_cnt[s]++;
    retire_rank(slot_rank[s]);
    slot_rank[s] = n_used - 1;
  endfunction

  function automatic reply_t compute_reply(logic op, logic [DATA_W-1:0] k,
                                           logic [DATA_W-1:0] v);
    reply_t      r;
    int          s;
    int          slot;
    int unsigned lim;
    r    = '0;
    s    = -1;
    slot = -1;
    lim  = (cap_reg > SLOTS) ? SLOTS : cap_reg;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && slot_used[i] && slot_key[i] == k) s = i;
    r.hit = (s >= 0);
    if (op == OP_GET) begin
      if (s >= 0) begin
        bump_use(s);
        r.read_value = slot_val[s];
      end
    end else if (lim != 0) begin
      if (s >= 0) begin
        slot_val[s] = v;
        bump_use(s);
      end else begin
        if (n_used >= lim) begin
          // lowest count, earliest rank among equals
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i]) continue;
            if (slot < 0 || slot_cnt[i] < slot_cnt[slot] ||
                (slot_cnt[i] == slot_cnt[slot] && slot_rank[i] < slot_rank[slot]))
              slot = i;
          end
          if (slot >= 0) begin
            r.evicted     = 1'b1;
            r.evicted_key = slot_key[slot];
            retire_rank(slot_rank[slot]);
            slot_used[slot] = 1'b0;
            n_used--;
          end
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !slot_used[i]) slot = i;
        end
        if (slot >= 0) begin
          slot_used[slot] = 1'b1;
          slot_key[slot]  = k;
          slot_val[slot]  = v;
          slot_cnt[slot]  = 1;
          slot_rank[slot] = n_used;
          n_used++;
        end
      end
    end
    return r;
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------
  // Reply checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_beat
    reply_t got;
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.hit         = out_hit;
      got.read_value  = out_read_value;
      got.evicted     = out_evicted;
      got.evicted_key = out_evicted_key;
      if (due_wr == due_rd) begin
        flag_error($sformatf("unexpected reply beat: hit=%0b rd=%h ev=%0b evk=%h",
                             got.hit, got.read_value, got.evicted, got.evicted_key));
      end else begin
        want = due_take();
        if (got.hit !== want.hit || got.read_value !== want.read_value ||
            got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
          flag_error($sformatf({"reply mismatch: exp hit=%0b rd=%h ev=%0b evk=%h",
                                " got hit=%0b rd=%h ev=%0b evk=%h"},
                               want.hit, want.read_value, want.evicted, want.evicted_key,
                               got.hit, got.read_value, got.evicted, got.evicted_key));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver stall pattern: segments of none, light, heavy or near-total stall
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 20;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end else begin
      stall_left--;
    end
    out_stall <= stalls_on && ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------
  task automatic send_request(logic op, logic [DATA_W-1:0] key,
                              logic [DATA_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b1;
    in_op    <= op;
    in_key   <= key;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_put(compute_reply(op, key, val));
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off new requests until every reply is back
  task automatic drain_replies;
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr && addr[2] == REG_CAPACITY) cap_reg = wdata[CAP_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_capacity_readback;
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, CAP_ADDR, '0, rd);
    if (rd !== {{(DATA_W-CAP_W){1'b0}}, cap_reg})
      flag_error($sformatf("capacity readback: exp %0d got %h", cap_reg, rd));
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    logic [DATA_W-1:0] rd;
    drain_replies();
    apb_xfer(1'b1, CAP_ADDR, {{(DATA_W-CAP_W){1'b0}}, cap}, rd);
    check_capacity_readback();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // two entries bumped to the same count back to back with no receiver
  // stalls; the one that got there first is the victim
  task automatic test_count_tie;
    logic [DATA_W-1:0] key_a;
    logic [DATA_W-1:0] key_b;
    key_a = 32'h5A5A_0001;
    key_b = 32'hA5A5_FFFE;
    stalls_on = 1'b0;
    set_capacity(2);
    send_request(OP_PUT, key_a, 32'h1111_1111);
    send_request(OP_PUT, key_b, 32'h2222_2222);
    repeat (3) send_request(OP_GET, key_a, $urandom);
    repeat (3) send_request(OP_GET, key_b, $urandom);
    send_request(OP_PUT, 32'h0BAD_F00D, 32'h3333_3333);
    send_request(OP_GET, key_a, $urandom);
    send_request(OP_GET, key_b, $urandom);
    drain_replies();
    stalls_on = 1'b1;
  endtask

  // extreme keys and values, miss, hit, in-place update
  task automatic test_basic_access;
    set_capacity(16);
    send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0005);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
  endtask

  // capacity below fill level, then LFU victim with oldest-first tie break
  task automatic test_eviction_order;
    set_capacity(3);
    send_request(OP_PUT, 32'h0000_0101, 32'hA);
    send_request(OP_PUT, 32'h0000_0102, 32'hB);
    send_request(OP_GET, 32'h0000_0101, 32'h0);
    send_request(OP_PUT, 32'h0000_0103, 32'hC);
    send_request(OP_GET, 32'h0000_0102, 32'h0);
  endtask

  // puts ignored, hit still reported, earlier entries readable
  task automatic test_capacity_zero;
    set_capacity(0);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
    send_request(OP_PUT, 32'h1234_5678, 32'h1);
    send_request(OP_GET, 32'h1234_5678, 32'h0);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
  endtask

  // capacity above the slot count, write to an unmapped address, capacity 1
  task automatic test_capacity_limits;
    logic [DATA_W-1:0] rd;
    set_capacity(31);
    apb_xfer(1'b1, SPARE_ADDR, 32'h0000_0001, rd);
    check_capacity_readback();
    send_request(OP_PUT, 32'h0000_0201, 32'h1);
    send_request(OP_PUT, 32'h0000_0202, 32'h2);
    set_capacity(1);
    send_request(OP_PUT, 32'h0000_0203, 32'h3);
    send_request(OP_GET, 32'h0000_0202, 32'h0);
  endtask

  // random traffic over a sequence of capacities
  task automatic test_random_traffic;
    logic [DATA_W-1:0] key_pool [POOL_SZ];
    logic [CAP_W-1:0]  caps [8];
    logic [DATA_W-1:0] key;
    logic              op;
    int                pool_used;
    int                burst_left;
    caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd3, 5'd12, 5'd0};
    caps[7] = $urandom_range(0, 31);
    for (int i = 0; i < POOL_SZ; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    burst_left = 0;
    for (int ph = 0; ph < 8; ph++) begin
      set_capacity(caps[ph]);
      // refresh part of the pool, keep the rest so old entries get hit
      for (int i = 0; i < 8; i++) key_pool[$urandom_range(4, POOL_SZ - 1)] = $urandom;
      pool_used = (caps[ph] == 0) ? 20 : ((caps[ph] + 4 > POOL_SZ) ? POOL_SZ : caps[ph] + 4);
      if (pool_used > POOL_SZ) pool_used = POOL_SZ;
      for (int n = 0; n < 132; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if ($urandom_range(0, 9) >= 4) idle_cycles($urandom_range(1, 6));
        end
        burst_left--;
        if (n == 66) drain_replies();
        op  = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
        key = ($urandom_range(0, 9) == 0) ? $urandom
                                          : key_pool[$urandom_range(0, pool_used - 1)];
        send_request(op, key, $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_count_tie();
    test_basic_access();
    test_eviction_order();
    test_capacity_zero();
    test_capacity_limits();
    test_random_traffic();
    drain_replies();
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_replacement_cache_core.sv
sim/tb_top.sv
